// File: hw/rtl/annexb_nal_scanner_unit_assert.svh
// Assertion macros shared by the scanner's RTL modules.
// No dependencies; each macro expands to one concurrent assertion.
`ifndef ANNEXB_NAL_SCANNER_UNIT_ASSERT_SVH
`define ANNEXB_NAL_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ANBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ANBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/anbs_pkg.sv
// Shared types, codes, constants and the NAL header classifier for the scanner.
// No dependencies; used by every RTL module of the block.
package anbs_pkg;

    // Configuration defaults.
    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 2;
    localparam int OUT_COUNT_W         = 16;

    // Scan phases.
    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_UNIT  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    // Stream status codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_START  = 2'd1;
    localparam logic [1:0] ERR_EMPTY  = 2'd2;
    localparam logic [1:0] ERR_HEADER = 2'd3;

    // Codec selection.
    localparam logic MODE_AVC  = 1'b0;
    localparam logic MODE_HEVC = 1'b1;

    // Byte values, the saturation limit of the small scan counters and the zero run a start code needs.
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [1:0] RUN_MAX    = 2'd3;
    localparam logic [1:0] RUN_START  = 2'd2;

    // NAL unit types, H.264.
    localparam logic [5:0] AVC_TYPE_LIMIT = 6'd24;
    localparam logic [5:0] AVC_VCL_FIRST  = 6'd1;
    localparam logic [5:0] AVC_IDR        = 6'd5;
    localparam logic [5:0] AVC_SPS        = 6'd7;
    localparam logic [5:0] AVC_PPS        = 6'd8;

    // NAL unit types, HEVC.
    localparam logic [5:0] HEVC_IRAP_FIRST = 6'd16;
    localparam logic [5:0] HEVC_IRAP_LAST  = 6'd23;
    localparam logic [5:0] HEVC_VCL_LAST   = 6'd31;
    localparam logic [5:0] HEVC_VPS        = 6'd32;
    localparam logic [5:0] HEVC_SPS        = 6'd33;
    localparam logic [5:0] HEVC_PPS        = 6'd34;
    localparam logic [5:0] HEVC_TYPE_MAX   = 6'd40;

    // Outcome of checking one unit's header.
    typedef struct packed {
        logic       ok;
        logic [1:0] err;
        logic [5:0] utype;
        logic       ps;
        logic       vcl;
        logic       key;
        logic [2:0] pbit;
    } class_t;

    // One word passed from the front end to the back end.
    typedef struct packed {
        logic       closed;
        logic [5:0] utype;
        logic       ps;
        logic       vcl;
        logic       key;
        logic [2:0] pbit;
        logic       done;
        logic [1:0] status;
    } event_t;

    // Checks a unit's header bytes and classifies the unit.
    function automatic class_t anbs_classify(input logic [7:0] h1, input logic [7:0] h2,
                                             input logic [1:0] tlen, input logic mode);
        class_t     c;
        logic [5:0] t;
        c = '0;
        t = '0;
        if (tlen == 2'd0) begin
            c.err = ERR_EMPTY;
        end else if (mode == MODE_AVC) begin
            t = {1'b0, h1[4:0]};
            if (h1[7] || (t == 6'd0) || (t >= AVC_TYPE_LIMIT)) begin
                c.err = ERR_HEADER;
            end else begin
                c.ok    = 1'b1;
                c.utype = t;
                c.ps    = (t == AVC_SPS) || (t == AVC_PPS);
                c.pbit  = (t == AVC_SPS) ? 3'b001 : ((t == AVC_PPS) ? 3'b010 : 3'b000);
                c.vcl   = (t >= AVC_VCL_FIRST) && (t <= AVC_IDR);
                c.key   = (t == AVC_IDR);
            end
        end else begin
            t = h1[6:1];
            if ((tlen < 2'd2) || h1[7] || (h2[2:0] == 3'd0) || (t > HEVC_TYPE_MAX)) begin
                c.err = ERR_HEADER;
            end else begin
                c.ok    = 1'b1;
                c.utype = t;
                c.ps    = (t >= HEVC_VPS) && (t <= HEVC_PPS);
                c.pbit  = (t == HEVC_VPS) ? 3'b001 :
                          ((t == HEVC_SPS) ? 3'b010 : ((t == HEVC_PPS) ? 3'b100 : 3'b000));
                c.vcl   = (t <= HEVC_VCL_LAST);
                c.key   = (t >= HEVC_IRAP_FIRST) && (t <= HEVC_IRAP_LAST);
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/anbs_front.sv
// Front end: start code search, unit tracking, header checks and sticky errors.
// Depends on anbs_pkg; emits one event word per closed unit or stream end.
module anbs_front import anbs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       codec_mode,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       ev_valid,
    output event_t     ev_data
);

    logic [1:0] phase_reg, phase_next;
    logic [1:0] zr_reg, zr_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] tl_reg, tl_next;
    logic [7:0] h1_reg, h1_next;
    logic [7:0] h2_reg, h2_next;
    logic [1:0] err_reg, err_next;
    class_t     cls_a, cls_b, hit;
    logic       closed;
    logic       start_code;

    // Next scan state for the byte in flight, following the stream grammar.
    always_comb begin
        phase_next = phase_reg;
        zr_next    = zr_reg;
        pos_next   = pos_reg;
        tl_next    = tl_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        err_next   = err_reg;
        hit        = '0;
        closed     = 1'b0;
        start_code = (in_byte == START_BYTE) && (zr_reg >= RUN_START);
        cls_a      = anbs_classify(h1_reg, h2_reg, tl_reg, codec_mode);
        if (in_fire) begin
            unique case (phase_reg)
                PH_SEEK: begin
                    if (in_byte == ZERO_BYTE) begin
                        if (zr_reg < RUN_MAX) zr_next = zr_reg + 2'd1;
                    end else if (start_code) begin
                        phase_next = PH_UNIT;
                        zr_next    = '0;
                        pos_next   = '0;
                        tl_next    = '0;
                        h1_next    = '0;
                        h2_next    = '0;
                    end else begin
                        err_next   = ERR_START;
                        phase_next = PH_DRAIN;
                    end
                end
                PH_UNIT: begin
                    if (start_code) begin
                        // A start code closes the current unit.
                        if (cls_a.ok) begin
                            closed   = 1'b1;
                            hit      = cls_a;
                            zr_next  = '0;
                            pos_next = '0;
                            tl_next  = '0;
                            h1_next  = '0;
                            h2_next  = '0;
                        end else begin
                            err_next   = cls_a.err;
                            phase_next = PH_DRAIN;
                        end
                    end else begin
                        if (pos_reg == 2'd0) h1_next = in_byte;
                        else if (pos_reg == 2'd1) h2_next = in_byte;
                        if (in_byte != ZERO_BYTE) begin
                            tl_next = (pos_reg >= 2'd1) ? 2'd2 : 2'd1;
                            zr_next = '0;
                        end else if (zr_reg < RUN_MAX) begin
                            zr_next = zr_reg + 2'd1;
                        end
                        if (pos_reg < RUN_MAX) pos_next = pos_reg + 2'd1;
                    end
                end
                default: begin
                    // Draining after an error: bytes are dropped.
                end
            endcase
        end

        // The final byte closes whatever is open.
        cls_b = anbs_classify(h1_next, h2_next, tl_next, codec_mode);
        if (in_fire && in_last && (err_next == ERR_NONE)) begin
            if (phase_next == PH_SEEK) begin
                err_next = ERR_START;
            end else if (phase_next == PH_UNIT) begin
                if (cls_b.ok) begin
                    closed = 1'b1;
                    hit    = cls_b;
                end else begin
                    err_next = cls_b.err;
                end
            end
        end

        ev_valid       = in_fire && (closed || in_last);
        ev_data.closed = closed;
        ev_data.utype  = hit.utype;
        ev_data.ps     = hit.ps;
        ev_data.vcl    = hit.vcl;
        ev_data.key    = hit.key;
        ev_data.pbit   = hit.pbit;
        ev_data.done   = in_last;
        ev_data.status = err_next;

        // The stream end rearms the scanner.
        if (in_fire && in_last) begin
            phase_next = PH_SEEK;
            zr_next    = '0;
            pos_next   = '0;
            tl_next    = '0;
            h1_next    = '0;
            h2_next    = '0;
            err_next   = ERR_NONE;
        end
    end

    // Scan state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK;
            zr_reg    <= '0;
            pos_reg   <= '0;
            tl_reg    <= '0;
            h1_reg    <= '0;
            h2_reg    <= '0;
            err_reg   <= ERR_NONE;
        end else begin
            phase_reg <= phase_next;
            zr_reg    <= zr_next;
            pos_reg   <= pos_next;
            tl_reg    <= tl_next;
            h1_reg    <= h1_next;
            h2_reg    <= h2_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: hw/rtl/anbs_queue.sv
// Short event queue between the front end and the back end.
// Depends on anbs_pkg and the assertion macro header.
`include "annexb_nal_scanner_unit_assert.svh"

module anbs_queue import anbs_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t wr_data,
    input  logic   pop,
    output event_t rd_data,
    output logic   full,
    output logic   not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    event_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ANBS_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full, "queue write while full")
    `ANBS_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, not_empty, "queue read while empty")
    `ANBS_ASSERT_NEXT(a_cnt_hold, aclk, aresetn, push == pop, $stable(cnt_reg),
        "queue fill count moved without net change")

endmodule

// File: hw/rtl/anbs_back.sv
// Back end: running unit totals, parameter set mask and the result register.
// Depends on anbs_pkg and the assertion macro header.
`include "annexb_nal_scanner_unit_assert.svh"

module anbs_back import anbs_pkg::*; #(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  event_t                 q_data,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_unit_closed,
    output logic [5:0]             m_unit_type,
    output logic                   m_is_param_set,
    output logic                   m_is_vcl,
    output logic                   m_is_key,
    output logic [OUT_COUNT_W-1:0] m_unit_total,
    output logic [OUT_COUNT_W-1:0] m_param_total,
    output logic [OUT_COUNT_W-1:0] m_vcl_total,
    output logic [OUT_COUNT_W-1:0] m_key_total,
    output logic [2:0]             m_param_seen_mask,
    output logic                   m_stream_done,
    output logic [1:0]             m_stream_status
);

    logic [COUNT_WIDTH-1:0] unit_cnt_reg, unit_cnt_next, unit_upd;
    logic [COUNT_WIDTH-1:0] param_cnt_reg, param_cnt_next, param_upd;
    logic [COUNT_WIDTH-1:0] vcl_cnt_reg, vcl_cnt_next, vcl_upd;
    logic [COUNT_WIDTH-1:0] key_cnt_reg, key_cnt_next, key_upd;
    logic [2:0]             mask_reg, mask_next, mask_upd;
    logic [31:0]            unit_ext, param_ext, vcl_ext, key_ext;
    logic                   valid_reg;

    logic                   closed_reg, ps_reg, vcl_reg, key_reg, done_reg;
    logic [5:0]             utype_reg;
    logic [1:0]             status_reg;
    logic [OUT_COUNT_W-1:0] unit_tot_reg, param_tot_reg, vcl_tot_reg, key_tot_reg;
    logic [2:0]             seen_reg;

    // Take the next word when the result register is free or being drained.
    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    // Saturating count updates for the word at the queue head.
    always_comb begin
        unit_upd  = unit_cnt_reg;
        param_upd = param_cnt_reg;
        vcl_upd   = vcl_cnt_reg;
        key_upd   = key_cnt_reg;
        mask_upd  = mask_reg | q_data.pbit;
        if (q_data.closed && (unit_cnt_reg != '1)) begin
            unit_upd = unit_cnt_reg + COUNT_WIDTH'(1);
        end
        if (q_data.ps && (param_cnt_reg != '1)) begin
            param_upd = param_cnt_reg + COUNT_WIDTH'(1);
        end
        if (q_data.vcl && (vcl_cnt_reg != '1)) begin
            vcl_upd = vcl_cnt_reg + COUNT_WIDTH'(1);
        end
        if (q_data.key && (key_cnt_reg != '1)) begin
            key_upd = key_cnt_reg + COUNT_WIDTH'(1);
        end
        unit_ext  = 32'(unit_upd);
        param_ext = 32'(param_upd);
        vcl_ext   = 32'(vcl_upd);
        key_ext   = 32'(key_upd);

        // The stream end word clears the totals once it is reported.
        unit_cnt_next  = unit_cnt_reg;
        param_cnt_next = param_cnt_reg;
        vcl_cnt_next   = vcl_cnt_reg;
        key_cnt_next   = key_cnt_reg;
        mask_next      = mask_reg;
        if (q_pop) begin
            if (q_data.done) begin
                unit_cnt_next  = '0;
                param_cnt_next = '0;
                vcl_cnt_next   = '0;
                key_cnt_next   = '0;
                mask_next      = '0;
            end else begin
                unit_cnt_next  = unit_upd;
                param_cnt_next = param_upd;
                vcl_cnt_next   = vcl_upd;
                key_cnt_next   = key_upd;
                mask_next      = mask_upd;
            end
        end
    end

    // Totals and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_cnt_reg  <= '0;
            param_cnt_reg <= '0;
            vcl_cnt_reg   <= '0;
            key_cnt_reg   <= '0;
            mask_reg      <= '0;
            valid_reg     <= 1'b0;
        end else begin
            unit_cnt_reg  <= unit_cnt_next;
            param_cnt_reg <= param_cnt_next;
            vcl_cnt_reg   <= vcl_cnt_next;
            key_cnt_reg   <= key_cnt_next;
            mask_reg      <= mask_next;
            if (q_pop) valid_reg <= 1'b1;
            else if (m_ready) valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each word taken from the queue.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            closed_reg    <= q_data.closed;
            utype_reg     <= q_data.utype;
            ps_reg        <= q_data.ps;
            vcl_reg       <= q_data.vcl;
            key_reg       <= q_data.key;
            done_reg      <= q_data.done;
            status_reg    <= q_data.status;
            unit_tot_reg  <= unit_ext[OUT_COUNT_W-1:0];
            param_tot_reg <= param_ext[OUT_COUNT_W-1:0];
            vcl_tot_reg   <= vcl_ext[OUT_COUNT_W-1:0];
            key_tot_reg   <= key_ext[OUT_COUNT_W-1:0];
            seen_reg      <= mask_upd;
        end
    end

    assign m_valid           = valid_reg;
    assign m_unit_closed     = closed_reg;
    assign m_unit_type       = utype_reg;
    assign m_is_param_set    = ps_reg;
    assign m_is_vcl          = vcl_reg;
    assign m_is_key          = key_reg;
    assign m_unit_total      = unit_tot_reg;
    assign m_param_total     = param_tot_reg;
    assign m_vcl_total       = vcl_tot_reg;
    assign m_key_total       = key_tot_reg;
    assign m_param_seen_mask = seen_reg;
    assign m_stream_done     = done_reg;
    assign m_stream_status   = status_reg;

    `ANBS_ASSERT_IMP(a_status_only_at_end, aclk, aresetn, valid_reg && !done_reg,
        status_reg == ERR_NONE, "error status on a result before the stream end")
    `ANBS_ASSERT_IMP(a_class_needs_unit, aclk, aresetn, valid_reg && !closed_reg,
        (utype_reg == '0) && !ps_reg && !vcl_reg && !key_reg,
        "unit class reported without a closed unit")
    `ANBS_ASSERT_IMP(a_key_is_vcl, aclk, aresetn, valid_reg && key_reg, vcl_reg,
        "key unit not marked as VCL")

endmodule

// File: hw/rtl/annexb_nal_scanner_unit.sv
// Usage notes: the scanner takes an Annex B byte stream on the s_ channel, one word
// per byte with s_last_byte on the final byte, and returns result words on the m_
// channel. A result comes out for every NAL unit that closes with a valid header
// and for the final byte of the stream, which carries stream_done and the status.
// codec_mode selects H.264 or HEVC header rules; write it through cfg_wr_en and
// cfg_wr_data while no bytes are in flight.
// Throughput: one byte per cycle, sustained while m_ready stays high.
// The front end scans the byte in the cycle it is accepted and pushes its event
// word into the queue at that same edge; the back end loads the word into its
// result register, where m_valid rises, once that register is free or draining.
// Stalls: when m_ready is low the result register holds, the event queue fills and
// s_ready drops once the queue (QUEUE_DEPTH words) is full.
// Reset: aresetn is synchronous and active low; it clears the scan state, the
// totals, the queue and codec_mode (H.264). After the final byte the scanner and
// totals rearm by themselves; codec_mode keeps its value.
// Depends on anbs_pkg, anbs_front, anbs_queue and anbs_back.
module annexb_nal_scanner_unit import anbs_pkg::*; #(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_stream_byte,
    input  logic                   s_last_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_unit_closed,
    output logic [5:0]             m_unit_type,
    output logic                   m_is_param_set,
    output logic                   m_is_vcl,
    output logic                   m_is_key,
    output logic [OUT_COUNT_W-1:0] m_unit_total,
    output logic [OUT_COUNT_W-1:0] m_param_total,
    output logic [OUT_COUNT_W-1:0] m_vcl_total,
    output logic [OUT_COUNT_W-1:0] m_key_total,
    output logic [2:0]             m_param_seen_mask,
    output logic                   m_stream_done,
    output logic [1:0]             m_stream_status
);

    logic   codec_mode_reg;
    logic   in_fire;
    logic   ev_valid;
    event_t ev_data;
    event_t q_data;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    // Codec selection register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= MODE_AVC;
        end else if (cfg_wr_en) begin
            codec_mode_reg <= cfg_wr_data;
        end
    end

    // Bytes are taken whenever the queue has room for an event.
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    anbs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .codec_mode (codec_mode_reg),
        .in_fire    (in_fire),
        .in_byte    (s_stream_byte),
        .in_last    (s_last_byte),
        .ev_valid   (ev_valid),
        .ev_data    (ev_data)
    );

    anbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_valid),
        .wr_data   (ev_data),
        .pop       (q_pop),
        .rd_data   (q_data),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    anbs_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_not_empty       (q_not_empty),
        .q_data            (q_data),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_closed     (m_unit_closed),
        .m_unit_type       (m_unit_type),
        .m_is_param_set    (m_is_param_set),
        .m_is_vcl          (m_is_vcl),
        .m_is_key          (m_is_key),
        .m_unit_total      (m_unit_total),
        .m_param_total     (m_param_total),
        .m_vcl_total       (m_vcl_total),
        .m_key_total       (m_key_total),
        .m_param_seen_mask (m_param_seen_mask),
        .m_stream_done     (m_stream_done),
        .m_stream_status   (m_stream_status)
    );

endmodule

// File: dv/nal_scan_checker.sv
// Checker for the Annex B NAL scanner: watches the config port and both channels.
// Predicts every result word from the accepted bytes and compares field by field.
// Depends on anbs_pkg for codec, phase, status and NAL type codes.
`timescale 1ns / 100ps

module nal_scan_checker import anbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_unit_closed,
    input  logic [5:0]  m_unit_type,
    input  logic        m_is_param_set,
    input  logic        m_is_vcl,
    input  logic        m_is_key,
    input  logic [15:0] m_unit_total,
    input  logic [15:0] m_param_total,
    input  logic [15:0] m_vcl_total,
    input  logic [15:0] m_key_total,
    input  logic [2:0]  m_param_seen_mask,
    input  logic        m_stream_done,
    input  logic [1:0]  m_stream_status,
    output int          mismatch_count,
    output int          words_waiting,
    output int          words_checked
);

    // One result word as the scanner should emit it.
    typedef struct packed {
        logic        closed;
        logic [5:0]  utype;
        logic        ps;
        logic        vcl;
        logic        key;
        logic [15:0] units;
        logic [15:0] params;
        logic [15:0] vcls;
        logic [15:0] keys;
        logic [2:0]  mask;
        logic        done;
        logic [1:0]  status;
    } scan_word_t;

    // Shadow of the scanner state.
    logic        codec;
    logic [1:0]  phase;
    logic [1:0]  zrun;
    logic [1:0]  upos;
    logic [1:0]  tlen;
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [15:0] n_units;
    logic [15:0] n_params;
    logic [15:0] n_vcls;
    logic [15:0] n_keys;
    logic [2:0]  seen_mask;
    logic [1:0]  err;
    scan_word_t  unit_info;
    scan_word_t  due_words[$];

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic new_unit();
        zrun = '0;
        upos = '0;
        tlen = '0;
        hdr0 = '0;
        hdr1 = '0;
    endtask

    task automatic clear_scan();
        phase = PH_SEEK;
        new_unit();
        n_units   = '0;
        n_params  = '0;
        n_vcls    = '0;
        n_keys    = '0;
        seen_mask = '0;
        err       = ERR_NONE;
    endtask

    task automatic raise(input logic [1:0] code);
        err   = code;
        phase = PH_DRAIN;
    endtask

    // Checks the header of the open unit; on success it updates the totals and
    // records the unit's class in unit_info.
    task automatic finish_unit(output logic ok);
        logic [5:0] t;
        logic [2:0] pbit;
        logic       ps;
        logic       vcl;
        logic       key;
        logic       bad;
        t    = '0;
        pbit = '0;
        ps   = 1'b0;
        vcl  = 1'b0;
        key  = 1'b0;
        bad  = 1'b0;
        ok   = 1'b0;
        if (tlen == 2'd0) begin
            raise(ERR_EMPTY);
        end else begin
            if (codec == MODE_AVC) begin
                t = {1'b0, hdr0[4:0]};
                if (hdr0[7] || t == 6'd0 || t >= AVC_TYPE_LIMIT) begin
                    bad = 1'b1;
                end else begin
                    ps   = (t == AVC_SPS) || (t == AVC_PPS);
                    pbit = (t == AVC_SPS) ? 3'b001 : ((t == AVC_PPS) ? 3'b010 : 3'b000);
                    vcl  = (t >= AVC_VCL_FIRST) && (t <= AVC_IDR);
                    key  = (t == AVC_IDR);
                end
            end else begin
                t = hdr0[6:1];
                if (tlen < 2'd2 || hdr0[7] || hdr1[2:0] == 3'd0 || t > HEVC_TYPE_MAX) begin
                    bad = 1'b1;
                end else begin
                    ps = (t >= HEVC_VPS) && (t <= HEVC_PPS);
                    if (ps) begin
                        pbit = 3'b001 << (t - HEVC_VPS);
                    end
                    vcl = (t <= HEVC_VCL_LAST);
                    key = (t >= HEVC_IRAP_FIRST) && (t <= HEVC_IRAP_LAST);
                end
            end
            if (bad) begin
                raise(ERR_HEADER);
            end else begin
                seen_mask = seen_mask | pbit;
                if (ps) begin
                    n_params = bump(n_params);
                end
                if (vcl) begin
                    n_vcls = bump(n_vcls);
                end
                if (key) begin
                    n_keys = bump(n_keys);
                end
                n_units = bump(n_units);
                unit_info.utype = t;
                unit_info.ps    = ps;
                unit_info.vcl   = vcl;
                unit_info.key   = key;
                ok = 1'b1;
            end
        end
    endtask

    // Advances the shadow state by one accepted byte and queues the word it causes.
    task automatic scan_byte(input logic [7:0] b, input logic is_last);
        logic       closed;
        logic       ok;
        scan_word_t w;
        closed = 1'b0;
        ok     = 1'b0;
        if (phase == PH_SEEK) begin
            if (b == ZERO_BYTE) begin
                if (zrun < RUN_MAX) begin
                    zrun = zrun + 2'd1;
                end
            end else if (b == START_BYTE && zrun >= RUN_START) begin
                phase = PH_UNIT;
                new_unit();
            end else begin
                raise(ERR_START);
            end
        end else if (phase == PH_UNIT) begin
            if (b == START_BYTE && zrun >= RUN_START) begin
                finish_unit(closed);
                if (err == ERR_NONE) begin
                    new_unit();
                end
            end else begin
                if (upos == 2'd0) begin
                    hdr0 = b;
                end else if (upos == 2'd1) begin
                    hdr1 = b;
                end
                if (b != ZERO_BYTE) begin
                    tlen = (upos >= 2'd1) ? 2'd2 : 2'd1;
                    zrun = '0;
                end else if (zrun < RUN_MAX) begin
                    zrun = zrun + 2'd1;
                end
                if (upos < 2'd3) begin
                    upos = upos + 2'd1;
                end
            end
        end

        // The final byte closes whatever is open, unless an error is pending.
        if (is_last && err == ERR_NONE) begin
            if (phase == PH_SEEK) begin
                raise(ERR_START);
            end else if (phase == PH_UNIT) begin
                finish_unit(ok);
                if (ok) begin
                    closed = 1'b1;
                end
            end
        end

        if (closed || is_last) begin
            w        = '0;
            w.closed = closed;
            if (closed) begin
                w.utype = unit_info.utype;
                w.ps    = unit_info.ps;
                w.vcl   = unit_info.vcl;
                w.key   = unit_info.key;
            end
            w.units  = n_units;
            w.params = n_params;
            w.vcls   = n_vcls;
            w.keys   = n_keys;
            w.mask   = seen_mask;
            w.done   = is_last;
            w.status = err;
            due_words.push_back(w);
        end
        if (is_last) begin
            clear_scan();
        end
    endtask

    task automatic field_check(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compares one accepted result word with the oldest prediction.
    task automatic check_word();
        scan_word_t want;
        if (due_words.size() == 0) begin
            $error("result word arrived with no prediction waiting");
            mismatch_count++;
        end else begin
            want = due_words.pop_front();
            field_check("unit_closed", 16'(want.closed), 16'(m_unit_closed));
            field_check("unit_type", 16'(want.utype), 16'(m_unit_type));
            field_check("is_param_set", 16'(want.ps), 16'(m_is_param_set));
            field_check("is_vcl", 16'(want.vcl), 16'(m_is_vcl));
            field_check("is_key", 16'(want.key), 16'(m_is_key));
            field_check("unit_total", want.units, m_unit_total);
            field_check("param_total", want.params, m_param_total);
            field_check("vcl_total", want.vcls, m_vcl_total);
            field_check("key_total", want.keys, m_key_total);
            field_check("param_seen_mask", 16'(want.mask), 16'(m_param_seen_mask));
            field_check("stream_done", 16'(want.done), 16'(m_stream_done));
            field_check("stream_status", 16'(want.status), 16'(m_stream_status));
        end
        words_checked++;
    endtask

    // Everything is sampled at the rising edge; inputs move on the falling edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            codec = MODE_AVC;
            clear_scan();
            unit_info = '0;
            due_words.delete();
            mismatch_count = 0;
            words_checked  = 0;
        end else begin
            if (cfg_wr_en) begin
                codec = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                scan_byte(s_stream_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                check_word();
            end
        end
        words_waiting = due_words.size();
    end

endmodule

// File: dv/tb_top.sv
// Top of the Annex B NAL scanner testbench: clock, reset, stimulus and verdict.
// Depends on anbs_pkg, the annexb_nal_scanner_unit RTL and nal_scan_checker.
`timescale 1ns / 100ps

module tb_top import anbs_pkg::*;;

    localparam int          STALL_LIMIT  = 1000;
    localparam int          PHASE_BYTES  = 115;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_stream_byte = '0;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_unit_closed;
    logic [5:0]  m_unit_type;
    logic        m_is_param_set;
    logic        m_is_vcl;
    logic        m_is_key;
    logic [15:0] m_unit_total;
    logic [15:0] m_param_total;
    logic [15:0] m_vcl_total;
    logic [15:0] m_key_total;
    logic [2:0]  m_param_seen_mask;
    logic        m_stream_done;
    logic [1:0]  m_stream_status;

    int          mismatch_count;
    int          words_waiting;
    int          words_checked;
    int          quiet_cycles  = 0;
    int          bytes_sent    = 0;
    int          streams_sent  = 0;
    logic        jitter_on     = 1'b0;
    logic        codec_sel     = MODE_AVC;
    logic [7:0]  stream_bytes[$];

    always #5 aclk = ~aclk;

    annexb_nal_scanner_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_stream_byte     (s_stream_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_closed     (m_unit_closed),
        .m_unit_type       (m_unit_type),
        .m_is_param_set    (m_is_param_set),
        .m_is_vcl          (m_is_vcl),
        .m_is_key          (m_is_key),
        .m_unit_total      (m_unit_total),
        .m_param_total     (m_param_total),
        .m_vcl_total       (m_vcl_total),
        .m_key_total       (m_key_total),
        .m_param_seen_mask (m_param_seen_mask),
        .m_stream_done     (m_stream_done),
        .m_stream_status   (m_stream_status)
    );

    nal_scan_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_stream_byte     (s_stream_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_closed     (m_unit_closed),
        .m_unit_type       (m_unit_type),
        .m_is_param_set    (m_is_param_set),
        .m_is_vcl          (m_is_vcl),
        .m_is_key          (m_is_key),
        .m_unit_total      (m_unit_total),
        .m_param_total     (m_param_total),
        .m_vcl_total       (m_vcl_total),
        .m_key_total       (m_key_total),
        .m_param_seen_mask (m_param_seen_mask),
        .m_stream_done     (m_stream_done),
        .m_stream_status   (m_stream_status),
        .mismatch_count    (mismatch_count),
        .words_waiting     (words_waiting),
        .words_checked     (words_checked)
    );

    // The result side stalls at random while jitter is enabled.
    always @(negedge aclk) begin
        m_ready <= !(jitter_on && $urandom_range(99) < 29);
    end

    // Watchdog: counts cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[annexb_nal_scanner_unit] ERROR");
        $finish;
    end

    // Offers one byte, with random gaps ahead of it, and waits until it is taken.
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        while (jitter_on && $urandom_range(99) < 29) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_stream_byte = b;
        s_last_byte   = is_last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Sends the buffered stream, marking its final byte.
    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++) begin
            push_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        streams_sent++;
    endtask

    // Writes codec_mode once every predicted word is out and the pipe is empty.
    task automatic set_codec(input logic m);
        @(negedge aclk);
        s_valid = 1'b0;
        wait (words_waiting == 0);
        repeat (4) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        codec_sel = m;
    endtask

    task automatic add_bytes(input int n, input logic [127:0] seq);
        for (int i = n - 1; i >= 0; i--) begin
            stream_bytes.push_back(seq[8*i +: 8]);
        end
    endtask

    task automatic add_start_code();
        repeat ($urandom_range(2, 4)) stream_bytes.push_back(ZERO_BYTE);
        stream_bytes.push_back(START_BYTE);
    endtask

    // Appends a NAL header for the current codec, mostly legal, sometimes broken.
    task automatic add_header(output logic one_byte);
        logic [5:0] t;
        logic [1:0] nri;
        logic [5:0] layer;
        logic [2:0] tid;
        logic       fbit;
        int         r;
        one_byte = 1'b0;
        r    = $urandom_range(99);
        fbit = ($urandom_range(99) < 6);
        if (codec_sel == MODE_AVC) begin
            nri = 2'($urandom_range(3));
            if (r < 8) begin
                t = ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(24, 31));
            end else begin
                case ($urandom_range(4))
                    0: t = AVC_SPS;
                    1: t = AVC_PPS;
                    2: t = AVC_IDR;
                    3: t = 6'($urandom_range(1, 4));
                    default: t = 6'($urandom_range(6, 23));
                endcase
            end
            stream_bytes.push_back({fbit, nri, t[4:0]});
        end else begin
            layer = ($urandom_range(99) < 80) ? 6'd0 : 6'($urandom_range(63));
            tid   = ($urandom_range(99) < 6) ? 3'd0 : 3'($urandom_range(1, 7));
            if (r < 8) begin
                t = 6'($urandom_range(HEVC_TYPE_MAX + 1, 63));
            end else begin
                case ($urandom_range(4))
                    0: t = 6'($urandom_range(HEVC_VPS, HEVC_PPS));
                    1: t = 6'($urandom_range(HEVC_IRAP_FIRST, HEVC_IRAP_LAST));
                    2: t = 6'($urandom_range(0, 15));
                    3: t = 6'($urandom_range(24, HEVC_VCL_LAST));
                    default: t = 6'($urandom_range(HEVC_PPS + 1, HEVC_TYPE_MAX));
                endcase
            end
            stream_bytes.push_back({fbit, t, layer[5]});
            if ($urandom_range(99) < 5) begin
                one_byte = 1'b1;
            end else begin
                stream_bytes.push_back({layer[4:0], tid});
            end
        end
    endtask

    // Builds one stream: mostly well formed units with random payload, plus a
    // few broken leads, empty units and endings on a start code or a zero.
    task automatic build_random_stream();
        int   r;
        int   units;
        logic one_byte;
        stream_bytes.delete();
        r = $urandom_range(99);
        if (r < 5) begin
            stream_bytes.push_back(8'($urandom_range(2, 255)));
        end else if (r < 8) begin
            stream_bytes.push_back(ZERO_BYTE);
            stream_bytes.push_back(START_BYTE);
        end
        add_start_code();
        units = $urandom_range(1, 5);
        for (int u = 0; u < units; u++) begin
            if ($urandom_range(99) >= 4) begin
                add_header(one_byte);
                if (!one_byte) begin
                    repeat ($urandom_range(0, 4))
                        stream_bytes.push_back(8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 2)) stream_bytes.push_back(ZERO_BYTE);
                end
            end
            if (u < units - 1) begin
                add_start_code();
            end
        end
        r = $urandom_range(99);
        if (r < 5) begin
            add_start_code();
        end else if (r < 9) begin
            stream_bytes.push_back(ZERO_BYTE);
        end
    endtask

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn   = 1'b1;
        jitter_on = 1'b1;

        // H.264 stream: SPS, PPS with a trailing zero, IDR closed by the final byte.
        stream_bytes.delete();
        add_bytes(13, 128'({8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01,
                            8'h68, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65}));
        send_stream();
        // Nonzero byte before any start code, on the final byte.
        stream_bytes.delete();
        add_bytes(1, 128'(8'hFF));
        send_stream();
        // Stream that ends without a start code.
        stream_bytes.delete();
        add_bytes(1, 128'(8'h00));
        send_stream();
        // Start code as the final byte gives an empty unit.
        stream_bytes.delete();
        add_bytes(3, 128'({8'h00, 8'h00, 8'h01}));
        send_stream();

        // HEVC stream: VPS then an IRAP slice closed by the final byte.
        set_codec(MODE_HEVC);
        stream_bytes.delete();
        add_bytes(10, 128'({8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01,
                            8'h26, 8'h01}));
        send_stream();

        // Random phases alternate the codec; the third runs without any stalls.
        for (int ph = 0; ph < 4; ph++) begin
            set_codec(ph[0] ? MODE_HEVC : MODE_AVC);
            jitter_on = (ph != 2);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                build_random_stream();
                send_stream();
            end
        end

        // Drain, then give the pipe time to show any stray word.
        jitter_on = 1'b1;
        @(negedge aclk);
        s_valid = 1'b0;
        wait (words_waiting == 0);
        repeat (8) @(negedge aclk);

        $display("Scanned %0d bytes in %0d streams under H.264 and HEVC rules, %0d words checked.",
                 bytes_sent, streams_sent, words_checked);
        $display("Run included start code and header errors, empty units and random stalls.");
        if (mismatch_count == 0) begin
            $display("[annexb_nal_scanner_unit] OK");
        end else begin
            $display("[annexb_nal_scanner_unit] ERROR");
        end
        $finish;
    end

endmodule
